/* rtl/core/bms_pkg.sv */
// Shared constants and types for the bilinear mask sampler.
`timescale 1ns / 1ps
`default_nettype none

package bms_pkg;

   localparam int COORD_W    = 25;
   localparam int WEIGHT_W   = 17;
   localparam int COL_W      = 10;
   localparam int SIZE_REG_W = 11;
   localparam int FRAME_W    = 16;
   localparam int FRAC_W     = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [WEIGHT_W-1:0] ONE_Q16 = 17'h10000;

   localparam logic CMD_SAMPLE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_MASK_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK_PRESENT = 3'd4;

   // Item fields that ride along every pipeline stage before the output register.
   typedef struct packed {
      logic                vld;
      logic                smp;
      logic [COL_W-1:0]    col;
      logic [COL_W-1:0]    row;
      logic [WEIGHT_W-1:0] wgt;
   } item_ctl_type;

endpackage

`default_nettype wire

/* rtl/core/bms_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module bms_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* rtl/core/bilinear_mask_sampler_core.sv */
// Top level of the bilinear mask sampler: pipelined scale, divide, clamp and blend.
`timescale 1ns / 1ps
`default_nettype none

// The core takes one item in every clock cycle; busy is always low and the
// receiver cannot stall it. A sample item returns its weight on rsp_weight_out
// with rsp_valid high for one cycle; most of the pipeline is the bit-per-stage
// divider by the frame size. Write items store one mask entry and return
// nothing. The mask sits in four banks split by row and column parity, so the
// four neighbors of a sample are read in the same cycle.
// The mask store is not cleared: read only entries that were written.
module bilinear_mask_sampler_core
   import bms_pkg::*;
#(
   parameter int MAX_DIM = 1024
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic                         req_cmd,
   input  wire logic        [COL_W-1:0]      req_write_col,
   input  wire logic        [COL_W-1:0]      req_write_row,
   input  wire logic        [WEIGHT_W-1:0]   req_write_weight,
   input  wire logic signed [COORD_W-1:0]    req_sample_u,
   input  wire logic signed [COORD_W-1:0]    req_sample_v,
   output logic                              rsp_valid,
   output logic             [WEIGHT_W-1:0]   rsp_weight_out,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic        [CSR_IDX_W-1:0]  csr_index,
   input  wire logic        [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CB  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int SW  = $clog2(MAX_DIM + 1);
   localparam int DH  = (CB > 1) ? CB - 1 : 1;
   localparam int BAW = 2 * DH;
   localparam int PW  = COORD_W + SW + 1;
   localparam int MW  = PW - 1;
   localparam int TW  = MW + 2;
   localparam int FW  = FRAME_W;
   localparam int WW  = 2 * WEIGHT_W;

   typedef struct packed {
      logic          neg;
      logic [MW-1:0] num;
      logic [FW-1:0] rem;
      logic [MW-1:0] quo;
   } div_lane_type;

   typedef struct packed {
      item_ctl_type ctl;
      div_lane_type lu;
      div_lane_type lv;
   } div_stage_type;

   typedef struct packed {
      logic [CB-1:0]     idx;
      logic [FRAC_W-1:0] frac;
   } axis_type;

   // Configuration registers.
   logic [SIZE_REG_W-1:0] mask_width_ff;
   logic [SIZE_REG_W-1:0] mask_height_ff;
   logic [FW-1:0]         frame_width_ff;
   logic [FW-1:0]         frame_height_ff;
   logic                  mask_present_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_width_ff   <= SIZE_REG_W'(1);
         mask_height_ff  <= SIZE_REG_W'(1);
         frame_width_ff  <= FW'(1);
         frame_height_ff <= FW'(1);
         mask_present_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MASK_WIDTH:   mask_width_ff   <= csr_wdata[SIZE_REG_W-1:0];
            CSR_MASK_HEIGHT:  mask_height_ff  <= csr_wdata[SIZE_REG_W-1:0];
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata[FW-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata[FW-1:0];
            CSR_MASK_PRESENT: mask_present_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   function automatic logic [SW-1:0] eff_size(input logic [SIZE_REG_W-1:0] s);
      logic [SW-1:0] r;
      if (s == '0) begin
         r = SW'(1);
      end else if (32'(s) > MAX_DIM) begin
         r = SW'(MAX_DIM);
      end else begin
         r = SW'(s);
      end
      return r;
   endfunction

   function automatic div_lane_type div_step(input div_lane_type a,
                                             input logic [FW-1:0] d);
      div_lane_type b;
      logic [FW:0]  r;
      logic         q;
      r = {a.rem, a.num[MW-1]};
      q = 1'b0;
      if (r >= {1'b0, d}) begin
         r = r - {1'b0, d};
         q = 1'b1;
      end
      b.neg = a.neg;
      b.num = {a.num[MW-2:0], 1'b0};
      b.rem = r[FW-1:0];
      b.quo = {a.quo[MW-2:0], q};
      return b;
   endfunction

   function automatic logic signed [TW-1:0] floor_t(input div_lane_type a);
      logic signed [TW-1:0] q;
      q = $signed(TW'(a.quo)) + $signed(TW'(a.rem != '0 && a.neg));
      return a.neg ? -q - TW'(128) : q - TW'(128);
   endfunction

   // Clamp to the edges; the last cell has no right neighbor, so its fraction
   // is dropped, which gives the same blend as repeating the edge entry.
   function automatic axis_type locate(input logic signed [TW-1:0] t,
                                       input logic [CB-1:0] last);
      logic signed [TW-1:0] pos;
      axis_type             a;
      pos = t >>> FRAC_W;
      if (pos < 0) begin
         a.idx  = '0;
         a.frac = '0;
      end else if (pos > $signed(TW'(last))) begin
         a.idx  = last;
         a.frac = '0;
      end else begin
         a.idx  = pos[CB-1:0];
         a.frac = t[FRAC_W-1:0];
      end
      if (a.idx == last) begin
         a.frac = '0;
      end
      return a;
   endfunction

   logic [SW-1:0] w_eff;
   logic [SW-1:0] h_eff;
   logic [CB-1:0] w_last;
   logic [CB-1:0] h_last;
   logic [FW-1:0] fw_eff;
   logic [FW-1:0] fh_eff;

   assign w_eff  = eff_size(mask_width_ff);
   assign h_eff  = eff_size(mask_height_ff);
   assign w_last = CB'(w_eff - SW'(1));
   assign h_last = CB'(h_eff - SW'(1));
   assign fw_eff = (frame_width_ff == '0) ? FW'(1) : frame_width_ff;
   assign fh_eff = (frame_height_ff == '0) ? FW'(1) : frame_height_ff;

   // Stage 1: input capture.
   item_ctl_type               ctl1_ff, ctl1_in;
   logic signed [COORD_W-1:0]  u1_ff, v1_ff;

   always_comb begin
      ctl1_in.vld = start && !busy;
      ctl1_in.smp = (req_cmd == CMD_SAMPLE);
      ctl1_in.col = req_write_col;
      ctl1_in.row = req_write_row;
      ctl1_in.wgt = req_write_weight;
   end

   always_ff @(posedge clock) begin
      u1_ff   <= req_sample_u;
      v1_ff   <= req_sample_v;
      if (reset) begin
         ctl1_ff.vld <= 1'b0;
      end else begin
         ctl1_ff <= ctl1_in;
      end
   end

   // Stage 2: scale by the mask size.
   item_ctl_type          ctl2_ff;
   logic signed [PW-1:0]  pu2_ff, pu2_in;
   logic signed [PW-1:0]  pv2_ff, pv2_in;

   assign pu2_in = PW'(u1_ff) * $signed(PW'(w_eff));
   assign pv2_in = PW'(v1_ff) * $signed(PW'(h_eff));

   always_ff @(posedge clock) begin
      pu2_ff  <= pu2_in;
      pv2_ff  <= pv2_in;
      if (reset) begin
         ctl2_ff.vld <= 1'b0;
      end else begin
         ctl2_ff <= ctl1_ff;
      end
   end

   // Divider by the frame size, one quotient bit per stage.
   div_stage_type ds_ff [MW+1];
   div_stage_type ds_in [MW+1];

   always_comb begin
      ds_in[0].ctl    = ctl2_ff;
      ds_in[0].lu.neg = pu2_ff[PW-1];
      ds_in[0].lu.num = MW'(pu2_ff[PW-1] ? -pu2_ff : pu2_ff);
      ds_in[0].lu.rem = '0;
      ds_in[0].lu.quo = '0;
      ds_in[0].lv.neg = pv2_ff[PW-1];
      ds_in[0].lv.num = MW'(pv2_ff[PW-1] ? -pv2_ff : pv2_ff);
      ds_in[0].lv.rem = '0;
      ds_in[0].lv.quo = '0;
   end

   for (genvar k = 0; k < MW; k++) begin : g_div
      always_comb begin
         ds_in[k+1].ctl = ds_ff[k].ctl;
         ds_in[k+1].lu  = div_step(ds_ff[k].lu, fw_eff);
         ds_in[k+1].lv  = div_step(ds_ff[k].lv, fh_eff);
      end
   end

   for (genvar k = 0; k <= MW; k++) begin : g_div_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            ds_ff[k].ctl.vld <= 1'b0;
         end else begin
            ds_ff[k] <= ds_in[k];
         end
      end
   end

   // Stage 4: floor quotient minus half a cell.
   item_ctl_type          ctl4_ff;
   logic signed [TW-1:0]  tu4_ff, tv4_ff;

   always_ff @(posedge clock) begin
      tu4_ff  <= floor_t(ds_ff[MW].lu);
      tv4_ff  <= floor_t(ds_ff[MW].lv);
      if (reset) begin
         ctl4_ff.vld <= 1'b0;
      end else begin
         ctl4_ff <= ds_ff[MW].ctl;
      end
   end

   // Stage 5: clamp to cells; the banks are addressed from here.
   item_ctl_type ctl5_ff;
   axis_type     ax5_ff, ay5_ff;

   always_ff @(posedge clock) begin
      ax5_ff  <= locate(tu4_ff, w_last);
      ay5_ff  <= locate(tv4_ff, h_last);
      if (reset) begin
         ctl5_ff.vld <= 1'b0;
      end else begin
         ctl5_ff <= ctl4_ff;
      end
   end

   logic [DH-1:0]       xe, xo, ye, yo;
   logic [DH-1:0]       wr_row_h, wr_col_h;
   logic                wr_ok;
   logic [WEIGHT_W-1:0] rd [4];

   assign xe       = DH'(({1'b0, ax5_ff.idx} + (CB+1)'(1)) >> 1);
   assign xo       = DH'({1'b0, ax5_ff.idx} >> 1);
   assign ye       = DH'(({1'b0, ay5_ff.idx} + (CB+1)'(1)) >> 1);
   assign yo       = DH'({1'b0, ay5_ff.idx} >> 1);
   assign wr_row_h = DH'(ctl5_ff.row >> 1);
   assign wr_col_h = DH'(ctl5_ff.col >> 1);
   assign wr_ok    = ctl5_ff.vld && !ctl5_ff.smp
                     && (32'(ctl5_ff.row) < MAX_DIM) && (32'(ctl5_ff.col) < MAX_DIM);

   // Bank b holds entries whose row parity is b[1] and column parity is b[0].
   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [BAW-1:0] raddr;
      logic           we;
      assign raddr = {((b / 2) != 0) ? yo : ye, ((b % 2) != 0) ? xo : xe};
      assign we    = wr_ok && ({ctl5_ff.row[0], ctl5_ff.col[0]} == 2'(b));
      bms_ram #(
         .WIDTH (WEIGHT_W),
         .DEPTH (2 ** BAW)
      ) u_bank (
         .clock (clock),
         .we    (we),
         .waddr ({wr_row_h, wr_col_h}),
         .wdata (ctl5_ff.wgt),
         .raddr (raddr),
         .rdata (rd[b])
      );
   end

   // Stage 6: bank data arrives; blend weights are formed alongside.
   item_ctl_type        ctl6_ff;
   logic                x0b6_ff, y0b6_ff, dxz6_ff, dyz6_ff;
   logic [WEIGHT_W-1:0] wt6_ff [4];
   logic [WEIGHT_W-1:0] wt6_in [4];
   logic [FRAC_W:0]     ax_lo, ay_lo, ax_hi, ay_hi;

   always_comb begin
      ax_hi     = {1'b0, ax5_ff.frac};
      ay_hi     = {1'b0, ay5_ff.frac};
      ax_lo     = (FRAC_W+1)'(256) - ax_hi;
      ay_lo     = (FRAC_W+1)'(256) - ay_hi;
      wt6_in[0] = WEIGHT_W'(ax_lo * ay_lo);
      wt6_in[1] = WEIGHT_W'(ax_hi * ay_lo);
      wt6_in[2] = WEIGHT_W'(ax_lo * ay_hi);
      wt6_in[3] = WEIGHT_W'(ax_hi * ay_hi);
   end

   always_ff @(posedge clock) begin
      x0b6_ff <= ax5_ff.idx[0];
      y0b6_ff <= ay5_ff.idx[0];
      dxz6_ff <= (ax5_ff.frac == '0);
      dyz6_ff <= (ay5_ff.frac == '0);
      wt6_ff  <= wt6_in;
      if (reset) begin
         ctl6_ff.vld <= 1'b0;
      end else begin
         ctl6_ff <= ctl5_ff;
      end
   end

   // Stage 7: weight each neighbor. A neighbor with zero blend weight is
   // forced to zero so a never-used entry cannot leak into the sum.
   item_ctl_type        ctl7_ff;
   logic [WW-1:0]       pr7_ff [4];
   logic [WW-1:0]       pr7_in [4];
   logic [WEIGHT_W-1:0] m [4];

   always_comb begin
      m[0] = rd[{y0b6_ff, x0b6_ff}];
      m[1] = dxz6_ff ? '0 : rd[{y0b6_ff, ~x0b6_ff}];
      m[2] = dyz6_ff ? '0 : rd[{~y0b6_ff, x0b6_ff}];
      m[3] = (dxz6_ff || dyz6_ff) ? '0 : rd[{~y0b6_ff, ~x0b6_ff}];
      for (int i = 0; i < 4; i++) begin
         pr7_in[i] = WW'(m[i]) * WW'(wt6_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      pr7_ff  <= pr7_in;
      if (reset) begin
         ctl7_ff.vld <= 1'b0;
      end else begin
         ctl7_ff <= ctl6_ff;
      end
   end

   // Stage 8: pairwise sums.
   item_ctl_type  ctl8_ff;
   logic [WW:0]   sa8_ff, sb8_ff;

   always_ff @(posedge clock) begin
      sa8_ff  <= {1'b0, pr7_ff[0]} + {1'b0, pr7_ff[1]};
      sb8_ff  <= {1'b0, pr7_ff[2]} + {1'b0, pr7_ff[3]};
      if (reset) begin
         ctl8_ff.vld <= 1'b0;
      end else begin
         ctl8_ff <= ctl7_ff;
      end
   end

   // Stage 9: round, saturate and drive the result; it is ONE_Q16 when no mask is present.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [WEIGHT_W-1:0] rsp_weight_ff, rsp_weight_in;
   logic [WW+1:0]       acc;
   logic [WW-15:0]      acc_sh;

   always_comb begin
      acc          = {1'b0, sa8_ff} + {1'b0, sb8_ff} + (WW+2)'(32768);
      acc_sh       = acc[WW+1:16];
      rsp_valid_in = ctl8_ff.vld && ctl8_ff.smp;
      if (!mask_present_ff) begin
         rsp_weight_in = ONE_Q16;
      end else if (acc_sh > (WW-14)'(ONE_Q16)) begin
         rsp_weight_in = ONE_Q16;
      end else begin
         rsp_weight_in = acc_sh[WEIGHT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_weight_ff <= rsp_weight_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_weight_out = rsp_weight_ff;

endmodule

`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for the bilinear mask sampler core.
`timescale 1ns / 1ps

module tb_top;
   import bms_pkg::*;

   localparam int  MASK_DIM  = 1024;
   localparam int  DRAIN_CYC = 80;
   localparam logic CMD_WRITE = 1'b0;

   logic                        clock;
   logic                        reset;
   logic                        start;
   logic                        busy;
   logic                        req_cmd;
   logic        [COL_W-1:0]     req_write_col;
   logic        [COL_W-1:0]     req_write_row;
   logic        [WEIGHT_W-1:0]  req_write_weight;
   logic signed [COORD_W-1:0]   req_sample_u;
   logic signed [COORD_W-1:0]   req_sample_v;
   logic                        rsp_valid;
   logic        [WEIGHT_W-1:0]  rsp_weight_out;
   logic                        csr_valid;
   logic                        csr_ready;
   logic        [CSR_IDX_W-1:0] csr_index;
   logic        [CSR_DATA_W-1:0] csr_wdata;

   // Local copy of the block's registers and mask contents.
   int unsigned        reg_mask_w, reg_mask_h, reg_frame_w, reg_frame_h;
   bit                 reg_present;
   logic [WEIGHT_W-1:0] mask_mem [int];
   logic [WEIGHT_W-1:0] expected_weights [$];
   int                 error_count;

   bilinear_mask_sampler_core #(.MAX_DIM(MASK_DIM)) u_top (
      .clock, .reset, .start, .busy, .req_cmd, .req_write_col, .req_write_row,
      .req_write_weight, .req_sample_u, .req_sample_v, .rsp_valid, .rsp_weight_out,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic longint floor_div(input longint n, input longint d);
      if (n >= 0) return n / d;
      return -((-n + d - 1) / d);
   endfunction

   function automatic int eff_dim(input int unsigned s);
      if (s == 0) return 1;
      return (s > MASK_DIM) ? MASK_DIM : s;
   endfunction

   // Maps one coordinate to a clamped cell pair and an 8-bit fraction.
   function automatic void map_axis(input longint coord, input int size, input int frame,
                                    output int c0, output int c1, output int fr);
      longint f, t, pos;
      f = (frame == 0) ? 1 : frame;
      t = floor_div(coord * size, f) - 128;
      pos = floor_div(t, 256);
      fr = int'(t - pos * 256);
      if (pos < 0) begin
         pos = 0;
         fr = 0;
      end else if (pos > size - 1) begin
         pos = size - 1;
         fr = 0;
      end
      c0 = int'(pos);
      c1 = (pos + 1 < size) ? int'(pos) + 1 : size - 1;
   endfunction

   function automatic longint entry_at(input int row, input int col);
      int key;
      key = row * MASK_DIM + col;
      return mask_mem.exists(key) ? longint'(mask_mem[key]) : 0;
   endfunction

   function automatic logic [WEIGHT_W-1:0] predict_weight(input logic signed [COORD_W-1:0] u,
                                                          input logic signed [COORD_W-1:0] v);
      int x0, x1, y0, y1, dx, dy;
      longint acc;
      if (!reg_present) return ONE_Q16;
      map_axis(longint'(u), eff_dim(reg_mask_w), reg_frame_w, x0, x1, dx);
      map_axis(longint'(v), eff_dim(reg_mask_h), reg_frame_h, y0, y1, dy);
      acc = entry_at(y0, x0) * (256 - dx) * (256 - dy) + entry_at(y0, x1) * dx * (256 - dy)
          + entry_at(y1, x0) * (256 - dx) * dy + entry_at(y1, x1) * dx * dy;
      acc = (acc + 32768) >>> 16;
      if (acc > 65536) acc = 65536;
      return acc[WEIGHT_W-1:0];
   endfunction

   // Sends one item; the expectation is formed at the edge that accepts it.
   task automatic send_item(input logic cmd, input int col, input int row, input int wgt,
                            input logic signed [COORD_W-1:0] u,
                            input logic signed [COORD_W-1:0] v);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start            <= 1'b1;
      req_cmd          <= cmd;
      req_write_col    <= col[COL_W-1:0];
      req_write_row    <= row[COL_W-1:0];
      req_write_weight <= wgt[WEIGHT_W-1:0];
      req_sample_u     <= u;
      req_sample_v     <= v;
      do @(posedge clock); while (busy);
      if (cmd == CMD_SAMPLE)
         expected_weights.push_back(predict_weight(u, v));
      else
         mask_mem[(row % MASK_DIM) * MASK_DIM + (col % MASK_DIM)] = wgt[WEIGHT_W-1:0];
   endtask

   function automatic logic [COORD_W-1:0] rand_coord();
      return COORD_W'($urandom());
   endfunction

   task automatic put_entry(input int row, input int col, input int wgt);
      send_item(CMD_WRITE, col, row, wgt, rand_coord(), rand_coord());
   endtask

   task automatic sample_at(input logic signed [COORD_W-1:0] u,
                            input logic signed [COORD_W-1:0] v);
      send_item(CMD_SAMPLE, $urandom_range(0, 1023), $urandom_range(0, 1023),
                $urandom_range(0, 65536), u, v);
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (expected_weights.size() != 0) @(posedge clock);
      // Write items still in the pipeline produce no result.
      repeat (DRAIN_CYC) @(posedge clock);
   endtask

   // Leaves csr_valid high; the caller drops it after the last write.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_MASK_WIDTH:   reg_mask_w  = value & 32'h7FF;
         CSR_MASK_HEIGHT:  reg_mask_h  = value & 32'h7FF;
         CSR_FRAME_WIDTH:  reg_frame_w = value & 32'hFFFF;
         CSR_FRAME_HEIGHT: reg_frame_h = value & 32'hFFFF;
         CSR_MASK_PRESENT: reg_present = value[0];
         default: ;
      endcase
   endtask

   task automatic configure(input int unsigned mw, input int unsigned mh,
                            input int unsigned fw, input int unsigned fh, input bit present);
      wait_idle();
      write_csr(CSR_MASK_WIDTH, mw);
      write_csr(CSR_MASK_HEIGHT, mh);
      write_csr(CSR_FRAME_WIDTH, fw);
      write_csr(CSR_FRAME_HEIGHT, fh);
      write_csr(CSR_MASK_PRESENT, 32'(present));
      csr_valid <= 1'b0;
   endtask

   // Writes every entry of the active mask so that no sample reads an unset entry.
   task automatic fill_mask();
      for (int r = 0; r < eff_dim(reg_mask_h); r++)
         for (int c = 0; c < eff_dim(reg_mask_w); c++)
            put_entry(r, c, ($urandom_range(0, 7) == 0) ? 65536 : $urandom_range(0, 65536));
   endtask

   // Coordinate mostly near the frame, sometimes anywhere in the field range.
   function automatic logic [COORD_W-1:0] frame_coord(input int unsigned frame);
      int span;
      if ($urandom_range(0, 7) == 0) return rand_coord();
      span = ((frame == 0) ? 1 : frame) * 256;
      return COORD_W'($urandom_range(0, 3 * span) - span);
   endfunction

   task automatic random_samples(input int count, input bit drain_midway);
      for (int i = 0; i < count; i++) begin
         if (drain_midway && i == count / 2) wait_idle();
         if ($urandom_range(0, 15) == 0)
            put_entry($urandom_range(0, eff_dim(reg_mask_h) - 1),
                      $urandom_range(0, eff_dim(reg_mask_w) - 1), $urandom_range(0, 65536));
         else
            sample_at(frame_coord(reg_frame_w), frame_coord(reg_frame_h));
      end
   endtask

   task automatic test_no_mask();
      sample_at(25'h0, 25'h0);
      sample_at(25'h1000000, 25'h0FFFFFF);
      sample_at(25'h0FFFFFF, 25'h1000000);
      sample_at(rand_coord(), rand_coord());
   endtask

   task automatic test_directed();
      configure(2, 2, 4, 4, 1'b1);
      put_entry(0, 0, 0);
      put_entry(0, 1, 65536);
      put_entry(1, 0, 32768);
      put_entry(1, 1, 12345);
      sample_at(25'h1000000, 25'h1000000);   // cells below zero on both axes
      sample_at(25'h0FFFFFF, 25'h0FFFFFF);   // cells past the far edge
      sample_at(25'd512, 25'd512);           // exact center of the frame
      sample_at(25'd300, 25'd700);
      sample_at(25'd256, 25'd0);
      configure(0, 0, 0, 0, 1'b1);           // zero sizes count as one
      put_entry(0, 0, 40000);
      sample_at(25'd77, 25'h1FFFF00);
      sample_at(25'h0FFFFFF, 25'd1);
      configure(3, 2, 65535, 65535, 1'b0);   // mask off again
      sample_at(25'd1000, 25'd1000);
   endtask

   task automatic test_wide_mask();
      configure(2047, 1, 65535, 0, 1'b1);    // width saturates to the maximum
      fill_mask();
      random_samples(60, 1'b0);
   endtask

   task automatic test_tall_mask();
      configure(1, 64, 1000, 65535, 1'b1);
      fill_mask();
      random_samples(60, 1'b0);
   endtask

   task automatic test_random_masks();
      for (int p = 0; p < 4; p++) begin
         configure($urandom_range(0, 12), $urandom_range(0, 12),
                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                               : $urandom_range(0, 64),
                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                               : $urandom_range(0, 64),
                   ($urandom_range(0, 5) != 0));
         fill_mask();
         random_samples(80, p == 1);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_weights.size() == 0) begin
            $error("unexpected result: weight_out actual %0d", rsp_weight_out);
            error_count++;
         end else begin
            if (rsp_weight_out !== expected_weights[0]) begin
               $error("weight_out mismatch: expected %0d actual %0d",
                      expected_weights[0], rsp_weight_out);
               error_count++;
            end
            void'(expected_weights.pop_front());
         end
      end
   end

   initial begin
      error_count      = 0;
      reg_mask_w       = 1;
      reg_mask_h       = 1;
      reg_frame_w      = 1;
      reg_frame_h      = 1;
      reg_present      = 1'b0;
      reset            = 1'b1;
      start            = 1'b0;
      req_cmd          = CMD_WRITE;
      req_write_col    = '0;
      req_write_row    = '0;
      req_write_weight = '0;
      req_sample_u     = '0;
      req_sample_v     = '0;
      csr_valid        = 1'b0;
      csr_index        = CSR_MASK_WIDTH;
      csr_wdata        = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_no_mask();
      test_directed();
      test_wide_mask();
      test_tall_mask();
      test_random_masks();

      start <= 1'b0;
      while (expected_weights.size() != 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

/* bilinear_mask_sampler_core.f */
rtl/core/bms_pkg.sv
rtl/core/bms_ram.sv
rtl/core/bilinear_mask_sampler_core.sv
test/tb_top.sv
